// ===== rtl/cfsg_pkg.sv =====
// cfsg_pkg: shared types and constants of the filled-circle span generator
// used by cfsg_row_pipe and circle_fill_span_generator; no dependencies
`timescale 1ns / 1ps

package cfsg_pkg;

  localparam int MAX_RADIUS = 31;
  localparam int RAD_W      = 5;
  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 13;
  localparam int RR_W       = 2 * RAD_W;
  localparam int NUM_K      = MAX_RADIUS + 1;

  localparam logic [SIZE_W-1:0] SCREEN_LIMIT  = 13'd4096;
  localparam logic [1:0]        LOW_BITS_MASK = 2'b11;

  // configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ROWS
  } state_t;

  // one row issued by the sequencer into the span pipeline
  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [RAD_W-1:0]   ady;
    logic signed [15:0] cx;
    logic [RR_W-1:0]    rr;
    logic [COORD_W-1:0] col_lo;
    logic [COORD_W-1:0] col_hi;
    logic [31:0]        color;
    logic               last;
    logic               empty;
  } row_tok_t;

endpackage

// ===== rtl/circle_fill_span_generator.sv =====
// circle_fill_span_generator: top level with configuration, command setup and row sequencer
// depends on cfsg_pkg and cfsg_row_pipe
`timescale 1ns / 1ps

// usage:
//   cfg channel: cfg_index 0 = screen width, 1 = screen height (13 bits, reset 640 x 480,
//   values above 4096 act as 4096); always ready, write only while the block is idle.
//   in channel: one circle command per transfer (center, radius, color).
//   out channel: one span per clipped row, top to bottom, last = 1 on the final one;
//   zero radius or a box fully off screen gives one empty span marked last.
// timing:
//   a command is taken in the idle state and its box is clipped in the setup state; then
//   the row sequencer issues its n clipped rows (1 to 63, or 1 when empty), one row per
//   cycle while the pipeline advances, before the next command transfer.
//   the span pipeline behind the sequencer passes each row through stages b, c and d and
//   the output register, one span per cycle while the receiver keeps out_ready high.
// reset: clears the sequencer and all pipeline valid bits, restores the screen size.
// stall: when out_ready is low with a span waiting, the whole pipeline and the row
//   sequencer hold; nothing is dropped or repeated.
module circle_fill_span_generator
  import cfsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  center_x,
  input  logic signed [15:0]  center_y,
  input  logic [RAD_W-1:0]    radius,
  input  logic [31:0]         color,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  span_row,
  output logic [COORD_W-1:0]  span_start,
  output logic [5:0]          span_length,
  output logic [31:0]         span_color,
  output logic                span_valid,
  output logic                last
);

  state_t state, state_next;

  logic [SIZE_W-1:0]  screen_width, screen_height;
  logic signed [15:0] cmd_cx, cmd_cy;
  logic [RAD_W-1:0]   cmd_r;
  logic [31:0]        cmd_color;

  // clipped box of the current command
  logic [COORD_W-1:0] row, row_hi, col_lo, col_hi;
  logic [RR_W-1:0]    rr;
  logic               empty_cmd;

  // issue register feeding the pipeline
  logic     va;
  row_tok_t tok_a, tok_next;
  logic     adv, issue, geom_load;

  logic [SIZE_W-1:0]  sw_eff, sh_eff;
  logic signed [16:0] x_lo, x_hi, y_lo, y_hi, sw_s, sh_s, dy, ndy;
  logic               off_box;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 13'd640;
      screen_height <= 13'd480;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // box clipping
  assign sw_eff = (screen_width > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_width;
  assign sh_eff = (screen_height > SCREEN_LIMIT) ? SCREEN_LIMIT : screen_height;
  assign sw_s   = $signed({4'd0, sw_eff});
  assign sh_s   = $signed({4'd0, sh_eff});
  assign x_lo   = $signed({cmd_cx[15], cmd_cx}) - $signed({12'd0, cmd_r});
  assign x_hi   = $signed({cmd_cx[15], cmd_cx}) + $signed({12'd0, cmd_r});
  assign y_lo   = $signed({cmd_cy[15], cmd_cy}) - $signed({12'd0, cmd_r});
  assign y_hi   = $signed({cmd_cy[15], cmd_cy}) + $signed({12'd0, cmd_r});
  // a zero-sized screen hides even a box that starts left of or above it
  assign off_box = (cmd_r == '0) || (sw_eff == '0) || (sh_eff == '0)
                   || (x_hi < 0) || (x_lo >= sw_s)
                   || (y_hi < 0) || (y_lo >= sh_s);

  // row token
  assign dy  = $signed({cmd_cy[15], cmd_cy}) - $signed({5'd0, row});
  assign ndy = -dy;

  always_comb begin
    tok_next.row    = row;
    tok_next.ady    = dy[16] ? ndy[RAD_W-1:0] : dy[RAD_W-1:0];
    tok_next.cx     = cmd_cx;
    tok_next.rr     = rr;
    tok_next.col_lo = col_lo;
    tok_next.col_hi = col_hi;
    tok_next.color  = cmd_color;
    tok_next.last   = empty_cmd || (row == row_hi);
    tok_next.empty  = empty_cmd;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_ROWS;
      ST_ROWS:  if (adv && tok_next.last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    geom_load = 1'b0;
    issue     = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready  = 1'b1;
      ST_SETUP: geom_load = 1'b1;
      ST_ROWS:  issue     = adv;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      va    <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) va <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_cx    <= center_x;
      cmd_cy    <= center_y;
      cmd_r     <= radius;
      cmd_color <= color;
    end
    if (geom_load) begin
      empty_cmd <= off_box;
      rr        <= {5'd0, cmd_r} * {5'd0, cmd_r};
      row       <= y_lo[16] ? '0 : y_lo[COORD_W-1:0];
      row_hi    <= (y_hi >= sh_s) ? COORD_W'(sh_eff - 13'd1) : y_hi[COORD_W-1:0];
      col_lo    <= x_lo[16] ? '0 : x_lo[COORD_W-1:0];
      col_hi    <= (x_hi >= sw_s) ? COORD_W'(sw_eff - 13'd1) : x_hi[COORD_W-1:0];
    end else if (issue && !tok_next.last) begin
      row <= row + 12'd1;
    end
    if (adv) tok_a <= tok_next;
  end

  cfsg_row_pipe u_row_pipe (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (va),
    .tok         (tok_a),
    .adv         (adv),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .span_row    (span_row),
    .span_start  (span_start),
    .span_length (span_length),
    .span_color  (span_color),
    .span_valid  (span_valid),
    .last        (last)
  );

  a_take_setup : assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_SETUP)
    else $error("command transfer not followed by setup");

  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    state == ST_ROWS && adv && tok_next.last |=> state == ST_IDLE && va && tok_a.last)
    else $error("final row issued without returning to idle");

  a_rows_order : assert property (@(posedge clk) disable iff (rst)
    issue && !tok_next.last && !empty_cmd |-> row < row_hi)
    else $error("row sequencer ran past the clipped box");

endmodule

// ===== rtl/cfsg_row_pipe.sv =====
// cfsg_row_pipe: four-stage span pipeline, one row token in and one span out per
// cycle while the output is taken; depends on cfsg_pkg
`timescale 1ns / 1ps

module cfsg_row_pipe
  import cfsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_valid,
  input  row_tok_t            tok,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COORD_W-1:0]  span_row,
  output logic [COORD_W-1:0]  span_start,
  output logic [5:0]          span_length,
  output logic [31:0]         span_color,
  output logic                span_valid,
  output logic                last
);

  // stage b: dy squared
  logic            vb;
  row_tok_t        tok_b;
  logic [RR_W-1:0] dy2_b;
  // stage c: coverage per half-width
  logic             vc;
  row_tok_t         tok_c;
  logic [NUM_K-1:0] cov_c;
  // stage d: half-width of the covered run
  logic             vd;
  row_tok_t         tok_d;
  logic [RAD_W-1:0] h_d;
  logic             has_d;

  logic [NUM_K-1:0]   cov_next;
  logic [RAD_W:0]     cnt;
  logic signed [16:0] left, right, lo_s, hi_s, clo_s, chi_s;
  logic               hit;
  logic [16:0]        len_w;

  // whole pipeline moves together; holds only while the output waits
  assign adv = !out_valid || out_ready;

  always_comb begin
    logic [RR_W:0] dsum;
    for (int k = 0; k < NUM_K; k++) begin
      dsum = 11'(k * k) + {1'b0, dy2_b};
      cov_next[k] = ({dsum[RR_W:2], ~LOW_BITS_MASK & dsum[1:0]}) <= {1'b0, tok_b.rr};
    end
  end

  // covered half-widths form a prefix, so the count minus one gives the widest one
  assign cnt = (RAD_W+1)'($countones(cov_c));

  assign left  = $signed({tok_d.cx[15], tok_d.cx}) - $signed({12'd0, h_d});
  assign right = $signed({tok_d.cx[15], tok_d.cx}) + $signed({12'd0, h_d});
  assign clo_s = $signed({5'd0, tok_d.col_lo});
  assign chi_s = $signed({5'd0, tok_d.col_hi});
  assign lo_s  = (left < clo_s) ? clo_s : left;
  assign hi_s  = (right > chi_s) ? chi_s : right;
  assign hit   = has_d && (lo_s <= hi_s);
  assign len_w = 17'(hi_s - lo_s + 17'sd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vb        <= tok_valid;
      vc        <= vb;
      vd        <= vc;
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_b <= tok;
      dy2_b <= {5'd0, tok.ady} * {5'd0, tok.ady};
      tok_c <= tok_b;
      cov_c <= cov_next;
      tok_d <= tok_c;
      has_d <= (cnt != '0);
      h_d   <= RAD_W'(cnt - 6'd1);
      if (tok_d.empty) begin
        span_row    <= '0;
        span_start  <= '0;
        span_length <= '0;
        span_color  <= '0;
        span_valid  <= 1'b0;
        last        <= 1'b1;
      end else if (!hit) begin
        span_row    <= tok_d.row;
        span_start  <= '0;
        span_length <= '0;
        span_color  <= '0;
        span_valid  <= 1'b0;
        last        <= tok_d.last;
      end else begin
        span_row    <= tok_d.row;
        span_start  <= lo_s[COORD_W-1:0];
        span_length <= len_w[5:0];
        span_color  <= tok_d.color;
        span_valid  <= 1'b1;
        last        <= tok_d.last;
      end
    end
  end

  a_span_len : assert property (@(posedge clk) disable iff (rst)
    out_valid && span_valid |-> span_length != 6'd0)
    else $error("filled span with zero length");

  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && !span_valid |-> span_length == 6'd0 && span_start == '0 && span_color == '0)
    else $error("empty span carries data");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    vd && !adv |=> vd)
    else $error("stage d lost its row during a stall");

endmodule

// ===== bench/cfsg_span_checker.sv =====
// cfsg_span_checker: watches the config, command and span channels of the circle span
// generator, predicts the spans of every accepted command and compares them in order
// depends on cfsg_pkg
`timescale 1ns / 1ps

module cfsg_span_checker
  import cfsg_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [SIZE_W-1:0]   cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic signed [15:0]  center_x,
  input  logic signed [15:0]  center_y,
  input  logic [RAD_W-1:0]    radius,
  input  logic [31:0]         color,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [COORD_W-1:0]  span_row,
  input  logic [COORD_W-1:0]  span_start,
  input  logic [5:0]          span_length,
  input  logic [31:0]         span_color,
  input  logic                span_valid,
  input  logic                last,
  output int                  n_errors,
  output int                  n_pending
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] start;
    logic [5:0]         length;
    logic [31:0]        color;
    logic               valid;
    logic               last;
  } span_t;

  span_t             spans_due[$];
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;
  int                n_bad = 0;

  // distance test with the two low bits of the squared distance dropped
  function automatic bit in_disc(input int dx, input int dy, input int rr);
    int d;
    d = dx * dx + dy * dy;
    d = d & ~3;
    return d <= rr;
  endfunction

  function automatic void predict_spans(input int cx, input int cy, input int r,
                                        input logic [31:0] col);
    int    sw, sh, bx, by, bw, bh, rr, iy, row, dy, left, right;
    span_t s;
    sw = int'((scr_w > SCREEN_LIMIT) ? SCREEN_LIMIT : scr_w);
    sh = int'((scr_h > SCREEN_LIMIT) ? SCREEN_LIMIT : scr_h);
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    s = '0;
    s.last = 1'b1;
    if (r == 0) begin
      spans_due.push_back(s);
      return;
    end
    bx = cx - r;
    by = cy - r;
    bw = 2 * r + 1;
    bh = bw;
    if (bx < 0) begin
      bw = bw + bx;
      bx = 0;
    end
    if (by < 0) begin
      bh = bh + by;
      by = 0;
    end
    if (bx >= sw || by >= sh || bw <= 0 || bh <= 0) begin
      spans_due.push_back(s);
      return;
    end
    if (bx + bw >= sw) bw = sw - bx;
    if (by + bh >= sh) bh = sh - by;
    rr = r * r;
    for (iy = 0; iy < bh; iy++) begin
      row   = by + iy;
      dy    = cy - row;
      left  = 0;
      right = bw - 1;
      s      = '0;
      s.row  = row[COORD_W-1:0];
      s.last = (iy == bh - 1);
      while (left < bw && !in_disc(cx - (bx + left), dy, rr)) left++;
      if (left < bw) begin
        while (right > left && !in_disc(cx - (bx + right), dy, rr)) right--;
        s.start  = COORD_W'(bx + left);
        s.length = 6'(right + 1 - left);
        s.color  = col;
        s.valid  = 1'b1;
      end
      spans_due.push_back(s);
    end
  endfunction

  always @(posedge clk) begin
    span_t got, want;
    if (rst) begin
      spans_due.delete();
      scr_w = 13'd640;
      scr_h = 13'd480;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCREEN_WIDTH) scr_w = cfg_data;
        else scr_h = cfg_data;
      end
      if (out_valid && out_ready) begin
        got = '{span_row, span_start, span_length, span_color, span_valid, last};
        if (spans_due.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_LIMIT)
            $display("%0t: unexpected span row %0d start %0d len %0d color %h valid %b last %b",
                     $realtime, got.row, got.start, got.length, got.color, got.valid,
                     got.last);
        end else begin
          want = spans_due.pop_front();
          if (got.row !== want.row || got.start !== want.start ||
              got.length !== want.length || got.color !== want.color ||
              got.valid !== want.valid || got.last !== want.last) begin
            n_bad++;
            if (n_bad <= REPORT_LIMIT) begin
              $display("%0t: span mismatch, expected row %0d start %0d len %0d color %h valid %b last %b",
                       $realtime, want.row, want.start, want.length, want.color, want.valid,
                       want.last);
              $display("%0t:                  got row %0d start %0d len %0d color %h valid %b last %b",
                       $realtime, got.row, got.start, got.length, got.color, got.valid,
                       got.last);
            end
          end
        end
      end
      // command transfer after the span check so the queue stays in order
      if (in_valid && in_ready)
        predict_spans(int'(center_x), int'(center_y), int'(radius), color);
    end
    n_pending <= spans_due.size();
    n_errors  <= n_bad;
  end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: stimulus, clock, reset and verdict for circle_fill_span_generator
// depends on cfsg_pkg, circle_fill_span_generator and cfsg_span_checker
`timescale 1ns / 1ps

module tb_top;
  import cfsg_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = REG_SCREEN_WIDTH;
  logic [SIZE_W-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [15:0]  center_x = '0;
  logic signed [15:0]  center_y = '0;
  logic [RAD_W-1:0]    radius = '0;
  logic [31:0]         color = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [COORD_W-1:0]  span_row;
  logic [COORD_W-1:0]  span_start;
  logic [5:0]          span_length;
  logic [31:0]         span_color;
  logic                span_valid;
  logic                last;
  int                  n_errors;
  int                  n_pending;

  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int ready_hold = 0;
  int quiet_cycles = 0;
  int cur_w = 640;
  int cur_h = 480;

  circle_fill_span_generator dut (.*);

  cfsg_span_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: ready drops for bursts of random length
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(input int cx, input int cy, input int rad, input logic [31:0] col);
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    center_x <= cx[15:0];
    center_y <= cy[15:0];
    radius   <= rad[RAD_W-1:0];
    color    <= col;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic finish_commands();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [SIZE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers only change once every span of earlier commands is out
  task automatic write_screen(input int w, input int h);
    finish_commands();
    write_reg(REG_SCREEN_WIDTH, w[SIZE_W-1:0]);
    write_reg(REG_SCREEN_HEIGHT, h[SIZE_W-1:0]);
    cfg_valid <= 1'b0;
    cur_w = w;
    cur_h = h;
  endtask

  task automatic run_random(input int n, input int gap_pct, input int stall_pct);
    int lw, lh, cx, cy, rad, pick;
    in_gap_pct     = gap_pct;
    out_stall_pct <= stall_pct;
    lw = (cur_w > 4096) ? 4096 : cur_w;
    lh = (cur_h > 4096) ? 4096 : cur_h;
    repeat (n) begin
      // mostly near the visible area, sometimes anywhere in the 16-bit range
      if ($urandom_range(0, 9) < 7) begin
        cx = int'($urandom_range(0, lw + 80)) - 40;
        cy = int'($urandom_range(0, lh + 80)) - 40;
      end else begin
        cx = $urandom;
        cy = $urandom;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) rad = 0;
      else if (pick < 3) rad = $urandom_range(25, 31);
      else rad = $urandom_range(1, 12);
      send_cmd(cx, cy, rad, $urandom);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset screen of 640 x 480
    send_cmd(320, 240, 0, 32'hFFFF_FFFF);
    send_cmd(320, 240, 31, 32'hA5A5_5A5A);
    send_cmd(0, 0, 1, 32'h0000_0000);
    send_cmd(-32768, -32768, 31, 32'hFFFF_FFFF);
    send_cmd(32767, 32767, 31, 32'h1234_5678);
    send_cmd(-31, 100, 31, 32'hDEAD_BEEF);
    send_cmd(-32, 100, 31, 32'h0F0F_0F0F);
    send_cmd(100, -32, 31, 32'hF0F0_F0F0);
    send_cmd(670, 100, 31, 32'h5555_AAAA);
    send_cmd(671, 100, 31, 32'hAAAA_5555);
    send_cmd(639, 479, 20, 32'h0000_FFFF);
    send_cmd(-5, 100, 10, 32'hFFFF_0000);
    send_cmd(200, 200, 2, 32'h8000_0001);
    send_cmd(-1, -1, 3, 32'h7FFF_FFFE);

    // one-pixel screen
    write_screen(1, 1);
    send_cmd(0, 0, 31, 32'h1111_1111);
    send_cmd(1, 1, 1, 32'h2222_2222);

    write_screen(4096, 4096);
    send_cmd(4095, 4095, 31, 32'h3333_3333);
    send_cmd(4100, 2000, 5, 32'h4444_4444);
    send_cmd(2047, -30, 31, 32'h6666_6666);

    // sizes above the limit act as the limit
    write_screen(8191, 8191);
    send_cmd(4110, 4090, 20, 32'h7777_7777);

    // zero width or height hides everything
    write_screen(0, 480);
    send_cmd(10, 10, 5, 32'h9999_9999);
    write_screen(640, 0);
    send_cmd(10, 10, 5, 32'hBBBB_BBBB);

    write_screen(640, 480);
    run_random(50, 20, 20);
    write_screen(5, 3);
    run_random(20, 0, 0);
    write_screen(4096, 4096);
    run_random(40, 30, 30);
    write_screen($urandom_range(1, 8191), $urandom_range(1, 8191));
    run_random(40, 15, 25);
    write_screen(8191, 0);
    run_random(10, 10, 10);
    write_screen(100, 60);
    run_random(50, 25, 40);
    write_screen(640, 480);
    run_random(40, 0, 0);

    finish_commands();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cfsg_pkg.sv
rtl/cfsg_row_pipe.sv
rtl/circle_fill_span_generator.sv
bench/cfsg_span_checker.sv
bench/tb_top.sv
